// File: hdl/vral_pkg.sv
// ---------------------------------------------------------------------------
// vral_pkg: shared types and constants of the value, rate and acceleration limiter
// Holds the register indexes, the datapath widths and the structs passed
// between the pipeline sections.
// ---------------------------------------------------------------------------
package vral_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_VALUE_MIN = 3'd1;
  localparam logic [2:0] REG_VALUE_MAX = 3'd2;
  localparam logic [2:0] REG_RATE_MIN  = 3'd3;
  localparam logic [2:0] REG_RATE_MAX  = 3'd4;
  localparam logic [2:0] REG_ACCEL_MIN = 3'd5;
  localparam logic [2:0] REG_ACCEL_MAX = 3'd6;

  // Enable bit positions.
  localparam int EN_VALUE = 0;
  localparam int EN_RATE  = 1;
  localparam int EN_ACCEL = 2;

  // Widths: acceleration bounds, rate bounds and the working value.
  localparam int AW = 50;
  localparam int RW = 41;
  localparam int VW = 52;

  // Divider: quotient bits (Q16.16 numerator shifted by 16) and divisor bits.
  localparam int QW = 48;
  localparam int DW = 32;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         mask;
    logic signed [31:0] vmin;
    logic signed [31:0] vmax;
    logic signed [31:0] rmin;
    logic signed [31:0] rmax;
    logic signed [31:0] amin;
    logic signed [31:0] amax;
  } cfg_t;

  // Item after the bound computation.
  typedef struct packed {
    logic signed [31:0]   desired;
    logic signed [31:0]   p1;
    logic signed [32:0]   dv0;
    logic signed [33:0]   dd;
    logic signed [AW-1:0] alo;
    logic signed [AW-1:0] ahi;
    logic signed [RW-1:0] rlo;
    logic signed [RW-1:0] rhi;
  } bnd_t;

  // Item after all clamps.
  typedef struct packed {
    logic signed [31:0] lim;
    logic signed [31:0] desired;
  } lim_t;

endpackage

// File: hdl/vral_bounds.sv
// ---------------------------------------------------------------------------
// vral_bounds: limit bound computation
// Three stages: step differences and rate products, acceleration partial
// products of accel * 2*dt*dt, then the sum and the floor shift.
// ---------------------------------------------------------------------------
module vral_bounds
  import vral_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  cfg_t          cfg,
  input  logic          in_vld,
  input  logic [31:0]   desired,
  input  logic [31:0]   prev_value,
  input  logic [31:0]   prev_prev_value,
  input  logic [23:0]   time_step,
  output logic          out_vld,
  output bnd_t          out
);

  logic                 v1, v2;
  logic signed [31:0]   d1, p1_1, d2, p1_2;
  logic signed [32:0]   dv0_1, dv0_2;
  logic signed [33:0]   dd1, dd2;
  logic [47:0]          dtsq;
  logic signed [56:0]   rlo_p, rhi_p;
  logic signed [RW-1:0] rlo2, rhi2;
  logic signed [56:0]   amin_l, amax_l;
  logic signed [57:0]   amin_h, amax_h;
  logic [48:0]          dt2;
  logic signed [81:0]   asum_lo, asum_hi;

  assign dt2 = {dtsq, 1'b0};

  // Stage one: differences, dt squared and the rate products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
    if (adv) begin
      d1    <= desired;
      p1_1  <= prev_value;
      dv0_1 <= {prev_value[31], prev_value} - {prev_prev_value[31], prev_prev_value};
      dd1   <= {{2{desired[31]}}, desired} - {{2{prev_value[31]}}, prev_value}
               - ({{2{prev_value[31]}}, prev_value}
               - {{2{prev_prev_value[31]}}, prev_prev_value});
      dtsq  <= time_step * time_step;
      rlo_p <= $signed(cfg.rmin) * $signed({1'b0, time_step});
      rhi_p <= $signed(cfg.rmax) * $signed({1'b0, time_step});
    end
  end

  // Stage two: acceleration partial products over the split 2*dt*dt.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      d2     <= d1;
      p1_2   <= p1_1;
      dv0_2  <= dv0_1;
      dd2    <= dd1;
      rlo2   <= rlo_p[56:16];
      rhi2   <= rhi_p[56:16];
      amin_l <= $signed(cfg.amin) * $signed({1'b0, dt2[23:0]});
      amax_l <= $signed(cfg.amax) * $signed({1'b0, dt2[23:0]});
      amin_h <= $signed(cfg.amin) * $signed({1'b0, dt2[48:24]});
      amax_h <= $signed(cfg.amax) * $signed({1'b0, dt2[48:24]});
    end
  end

  // Stage three: combine the partial products and round toward minus infinity.
  assign asum_lo = (82'(amin_h) <<< 24) + 82'(amin_l);
  assign asum_hi = (82'(amax_h) <<< 24) + 82'(amax_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v2;
    end
    if (adv) begin
      out.desired <= d2;
      out.p1      <= p1_2;
      out.dv0     <= dv0_2;
      out.dd      <= dd2;
      out.rlo     <= rlo2;
      out.rhi     <= rhi2;
      out.alo     <= asum_lo[81:32];
      out.ahi     <= asum_hi[81:32];
    end
  end

endmodule

// File: hdl/vral_clamp.sv
// ---------------------------------------------------------------------------
// vral_clamp: limit application
// Three stages: acceleration clamp, rate clamp, then value clamp with
// saturation to 32 bits. Each clamp tests the lower bound first.
// ---------------------------------------------------------------------------
module vral_clamp
  import vral_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  cfg_t cfg,
  input  logic in_vld,
  input  bnd_t in,
  output logic out_vld,
  output lim_t out
);

  logic                 v4, v5;
  logic signed [VW-1:0] val4, val5;
  logic signed [31:0]   d4, p1_4, d5;
  logic signed [RW-1:0] rlo4, rhi4;
  logic signed [AW-1:0] dd_x, acl;
  logic signed [VW:0]   step, rlo_x, rhi_x, rcl;
  logic signed [VW-1:0] vmin_x, vmax_x, vcl;

  // Acceleration clamp on the change of step.
  always_comb begin
    dd_x = AW'(in.dd);
    if (dd_x < in.alo) begin
      acl = in.alo;
    end else if (dd_x > in.ahi) begin
      acl = in.ahi;
    end else begin
      acl = dd_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= in_vld;
    end
    if (adv) begin
      d4   <= in.desired;
      p1_4 <= in.p1;
      rlo4 <= in.rlo;
      rhi4 <= in.rhi;
      if (cfg.mask[EN_ACCEL]) begin
        val4 <= VW'(in.p1) + VW'(in.dv0) + VW'(acl);
      end else begin
        val4 <= VW'(in.desired);
      end
    end
  end

  // Rate clamp on the step from the previous value.
  always_comb begin
    step  = (VW+1)'(val4) - (VW+1)'(p1_4);
    rlo_x = (VW+1)'(rlo4);
    rhi_x = (VW+1)'(rhi4);
    if (step < rlo_x) begin
      rcl = rlo_x;
    end else if (step > rhi_x) begin
      rcl = rhi_x;
    end else begin
      rcl = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      d5 <= d4;
      if (cfg.mask[EN_RATE]) begin
        val5 <= VW'((VW+1)'(p1_4) + rcl);
      end else begin
        val5 <= val4;
      end
    end
  end

  // Value clamp, then saturation to the 32-bit range.
  always_comb begin
    vmin_x = VW'(cfg.vmin);
    vmax_x = VW'(cfg.vmax);
    vcl    = val5;
    if (cfg.mask[EN_VALUE]) begin
      if (val5 < vmin_x) begin
        vcl = vmin_x;
      end else if (val5 > vmax_x) begin
        vcl = vmax_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v5;
    end
    if (adv) begin
      out.desired <= d5;
      if (vcl < VW'(SAT_MIN)) begin
        out.lim <= SAT_MIN;
      end else if (vcl > VW'(SAT_MAX)) begin
        out.lim <= SAT_MAX;
      end else begin
        out.lim <= vcl[31:0];
      end
    end
  end

endmodule

// File: hdl/vral_div.sv
// ---------------------------------------------------------------------------
// vral_div: pipelined ratio divider
// Sign and magnitude preparation, one restoring quotient bit per stage,
// then sign, saturation and the desired-zero case in a final register.
// ---------------------------------------------------------------------------
module vral_div
  import vral_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  lim_t        in,
  output logic        out_vld,
  output logic [31:0] limited,
  output logic [31:0] ratio
);

  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] num  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic          neg  [0:QW];
  logic          zero [0:QW];
  logic [31:0]   lim  [0:QW];
  logic [31:0]   lmag, dmag;
  logic [QW-1:0] q;

  assign lmag = in.lim[31] ? 32'(-in.lim) : in.lim;
  assign dmag = in.desired[31] ? 32'(-in.desired) : in.desired;

  // Preparation: magnitudes and the sign of the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
    if (adv) begin
      rem[0]  <= '0;
      num[0]  <= {lmag, 16'h0000};
      quo[0]  <= '0;
      den[0]  <= dmag;
      neg[0]  <= in.lim[31] ^ in.desired[31];
      zero[0] <= (in.desired == '0);
      lim[0]  <= in.lim;
    end
  end

  // One quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        fit;

    assign trial = {rem[k], num[k][QW-1]};
    assign fit   = (trial >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        rem[k+1]  <= fit ? DW'(trial - {1'b0, den[k]}) : trial[DW-1:0];
        num[k+1]  <= {num[k][QW-2:0], 1'b0};
        quo[k+1]  <= {quo[k][QW-2:0], fit};
        den[k+1]  <= den[k];
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
        lim[k+1]  <= lim[k];
      end
    end
  end

  assign q = quo[QW];

  // Output register: sign, saturation and the desired-zero case.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld[QW];
    end
    if (adv) begin
      limited <= lim[QW];
      if (zero[QW]) begin
        ratio <= ONE_Q16;
      end else if (!neg[QW]) begin
        ratio <= (q > QW'(SAT_MAX)) ? SAT_MAX : q[31:0];
      end else begin
        ratio <= (q > QW'({1'b0, SAT_MIN})) ? SAT_MIN : 32'(-q[31:0]);
      end
    end
  end

endmodule

// File: hdl/value_rate_accel_limiter.sv
// ---------------------------------------------------------------------------
// value_rate_accel_limiter: second-order slew-rate limiter
// Applies acceleration, rate and value limits to a Q16.16 command and
// returns the limited value with its ratio to the requested value.
// ---------------------------------------------------------------------------
// The block takes one request per clock cycle while the pipeline advances, and
// returns one result per request, in order: three stages compute the
// bounds, three apply the clamps, and the ratio divider adds 50 stages (one
// quotient bit per stage for 48 bits, plus preparation and output). The
// whole pipeline advances when the output register is empty or being taken.
// The user must write limits through the configuration port only while no
// request is in flight; the block itself does not enforce this.
module value_rate_accel_limiter
  import vral_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // desired[31:0], prev_value[63:32], prev_prev_value[95:64], time_step[119:96]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // limited[31:0], ratio[63:32]
  output logic [63:0]  m_tdata
);

  localparam int LATENCY = 56;

  cfg_t        cfg;
  logic        adv;
  logic        b_vld, c_vld;
  bnd_t        b_out;
  lim_t        c_out;
  logic [31:0] limited, ratio;
  logic [6:0]  inflight;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tdata  = {ratio, limited};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    cfg.mask <= cfg_data[2:0];
        REG_VALUE_MIN: cfg.vmin <= cfg_data;
        REG_VALUE_MAX: cfg.vmax <= cfg_data;
        REG_RATE_MIN:  cfg.rmin <= cfg_data;
        REG_RATE_MAX:  cfg.rmax <= cfg_data;
        REG_ACCEL_MIN: cfg.amin <= cfg_data;
        REG_ACCEL_MAX: cfg.amax <= cfg_data;
        default: ;
      endcase
    end
  end

  vral_bounds u_bounds (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .cfg             (cfg),
    .in_vld          (s_tvalid),
    .desired         (s_tdata[31:0]),
    .prev_value      (s_tdata[63:32]),
    .prev_prev_value (s_tdata[95:64]),
    .time_step       (s_tdata[119:96]),
    .out_vld         (b_vld),
    .out             (b_out)
  );

  vral_clamp u_clamp (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .in_vld  (b_vld),
    .in      (b_out),
    .out_vld (c_vld),
    .out     (c_out)
  );

  vral_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (c_vld),
    .in      (c_out),
    .out_vld (m_tvalid),
    .limited (limited),
    .ratio   (ratio)
  );

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 7'(s_tvalid && s_tready) - 7'(m_tvalid && m_tready);
    end
  end

`ifndef SYNTHESIS
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 7'(LATENCY))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (inflight == '0) |-> !m_tvalid)
    else $error("result presented with no request in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");
`endif

endmodule

// File: test/vral_checker.sv
// ---------------------------------------------------------------------------
// vral_checker: result predictor and scoreboard for the limiter
// Watches the configuration port and both streams, predicts the limited
// value and its ratio for every accepted request and compares each result
// with the oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module vral_checker
  import vral_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  output int           fail_count,
  output int           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] ratio;
    logic signed [31:0] limited;
  } limit_result_t;

  // Own copy of the limit registers.
  logic [2:0]         lim_mask;
  logic signed [31:0] lim_vmin, lim_vmax, lim_rmin, lim_rmax, lim_amin, lim_amax;

  limit_result_t expected_results[$];

  function automatic wide_t clamp_wide(wide_t x, wide_t lo, wide_t hi);
    // Lower bound first: for an inverted pair, x below lo yields lo, else hi.
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic wide_t sat_s32(wide_t x);
    return clamp_wide(x, -wide_t'(64'sd2147483648), wide_t'(64'sd2147483647));
  endfunction

  function automatic limit_result_t limit_command(logic signed [31:0] desired,
                                                  logic signed [31:0] prev1,
                                                  logic signed [31:0] prev2,
                                                  logic [23:0] step);
    wide_t v, p1, p2, dt, dt2, dv0, dd, lo, hi, lim, q;
    limit_result_t r;
    v   = desired;
    p1  = prev1;
    p2  = prev2;
    dt  = $signed({104'b0, step});
    // Acceleration: bound the change of step by accel * 2*dt^2 (Q.48 down to Q.16).
    if (lim_mask[EN_ACCEL]) begin
      dv0 = p1 - p2;
      dd  = (v - p1) - dv0;
      dt2 = 2 * dt * dt;
      lo  = (wide_t'(lim_amin) * dt2) >>> 32;
      hi  = (wide_t'(lim_amax) * dt2) >>> 32;
      v   = p1 + dv0 + clamp_wide(dd, lo, hi);
    end
    // Rate: bound the step by rate * dt, rounded toward minus infinity.
    if (lim_mask[EN_RATE]) begin
      lo = (wide_t'(lim_rmin) * dt) >>> 16;
      hi = (wide_t'(lim_rmax) * dt) >>> 16;
      v  = p1 + clamp_wide(v - p1, lo, hi);
    end
    if (lim_mask[EN_VALUE])
      v = clamp_wide(v, wide_t'(lim_vmin), wide_t'(lim_vmax));
    lim = sat_s32(v);
    // Ratio from the saturated output, truncated toward zero.
    if (desired == 0) begin
      q = 65536;
    end else begin
      q = sat_s32((lim * 65536) / wide_t'(desired));
    end
    r.limited = lim[31:0];
    r.ratio   = q[31:0];
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    limit_result_t want, got;
    if (rst) begin
      lim_mask <= '0;
      lim_vmin <= '0;
      lim_vmax <= '0;
      lim_rmin <= '0;
      lim_rmax <= '0;
      lim_amin <= '0;
      lim_amax <= '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:    lim_mask <= cfg_data[2:0];
          REG_VALUE_MIN: lim_vmin <= cfg_data;
          REG_VALUE_MAX: lim_vmax <= cfg_data;
          REG_RATE_MIN:  lim_rmin <= cfg_data;
          REG_RATE_MAX:  lim_rmax <= cfg_data;
          REG_ACCEL_MIN: lim_amin <= cfg_data;
          REG_ACCEL_MAX: lim_amax <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(limit_command(s_tdata[31:0], s_tdata[63:32],
                                                 s_tdata[95:64], s_tdata[119:96]));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("Unexpected result: limited %0d ratio %0d", got.limited, got.ratio);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("Mismatch: limited %0d (expected %0d) ratio %0d (expected %0d)",
                       got.limited, want.limited, got.ratio, want.ratio);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for value_rate_accel_limiter
// Runs the limiter through every enable combination and several limit
// settings, with directed corner requests followed by random ones, random
// gaps on the input and random stalls on the output.
// ---------------------------------------------------------------------------
module testbench;
  import vral_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LATENCY_WAIT = 70;
  localparam int IDLE_LIMIT   = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  int           fail_count;
  int           outstanding;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           no_gaps = 1'b0;

  always #6 clk = ~clk;

  value_rate_accel_limiter dut (.*);

  vral_checker checker_i (.*);

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("value_rate_accel_limiter test failed");
      $finish;
    end
  end

  // Output stalls: stretches of random back-pressure, an occasional long
  // stall, and stretches without.
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 12000) % 3);
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (phase != 0 && $urandom_range(0, 99) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= int'($urandom_range(10, 40));
    end else if (phase == 0) m_tready <= 1'b1;
    else if (phase == 1) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 30) != 0);
  end

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 24'($urandom());
      1:       return ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'h0;
      default: return 24'($urandom_range(1, 1 << 17));
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic send_request(logic [31:0] desired, logic [31:0] p1, logic [31:0] p2,
                              logic [23:0] step);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {step, p2, p1, desired};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly a plausible trajectory (previous commands near each other, desired nearby), at times random values.
  task automatic send_trajectory();
    logic [31:0] p2, p1, d;
    if ($urandom_range(0, 4) == 0) begin
      send_request($urandom(), $urandom(), $urandom(), pick_step());
    end else begin
      p2 = pick_value();
      p1 = p2 + 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      d  = p1 + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      send_request(d, p1, p2, pick_step());
    end
  endtask

  task automatic set_limits(logic [2:0] mask, int style);
    write_reg(REG_ENABLE, {29'b0, mask});
    if (style == 0) begin
      // Widest limits.
      write_reg(REG_VALUE_MIN, 32'h8000_0000);
      write_reg(REG_VALUE_MAX, 32'h7FFF_FFFF);
      write_reg(REG_RATE_MIN,  32'h8000_0000);
      write_reg(REG_RATE_MAX,  32'h7FFF_FFFF);
      write_reg(REG_ACCEL_MIN, 32'h8000_0000);
      write_reg(REG_ACCEL_MAX, 32'h7FFF_FFFF);
    end else if (style == 1) begin
      // Inverted pairs: minimum above maximum.
      write_reg(REG_VALUE_MIN, pick_value() & 32'h7FFF_FFFF);
      write_reg(REG_VALUE_MAX, pick_value() | 32'h8000_0000);
      write_reg(REG_RATE_MIN,  32'h0001_0000);
      write_reg(REG_RATE_MAX,  32'hFFFF_0000);
      write_reg(REG_ACCEL_MIN, 32'h7FFF_FFFF);
      write_reg(REG_ACCEL_MAX, 32'h8000_0000);
    end else begin
      // Moderate, well-ordered limits.
      write_reg(REG_VALUE_MIN, -$urandom_range(0, 1 << 21));
      write_reg(REG_VALUE_MAX, $urandom_range(0, 1 << 21));
      write_reg(REG_RATE_MIN,  -$urandom_range(0, 1 << 20));
      write_reg(REG_RATE_MAX,  $urandom_range(0, 1 << 20));
      write_reg(REG_ACCEL_MIN, -$urandom_range(0, 1 << 20));
      write_reg(REG_ACCEL_MAX, $urandom_range(0, 1 << 20));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners with every limit on and moderate bounds.
    set_limits(3'b111, 2);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(32'h0, 32'h0, 32'h0, 24'h1_0000);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h0, 32'h0, 24'h0);
    send_request(32'h8000_0000, 32'h0, 32'h0, 24'h0);
    send_request(32'h0001_0000, 32'h0, 32'h0, 24'h0_0001);
    send_request(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 24'h0_8000);
    send_request(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_request(32'h0, 32'h8000_0000, 32'h8000_0000, 24'h1_0000);
    drain();
    set_limits(3'b111, 0);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_request(32'h0000_0001, 32'h0, 32'h0, 24'hFF_FFFF);
    send_request(32'h0, 32'h7FFF_FFFF, 32'h0, 24'h0);
    drain();
    set_limits(3'b111, 1);
    send_request(32'h0002_0000, 32'h0001_0000, 32'h0, 24'h1_0000);
    send_request(32'hFFFE_0000, 32'h0, 32'h0001_0000, 24'h1_0000);
    send_request(32'h7FFF_FFFF, 32'h0, 32'h0, 24'hFF_FFFF);
    send_request(32'h8000_0000, 32'h0, 32'h0, 24'hFF_FFFF);
    drain();

    // Random part: every enable combination, several limit settings.
    for (int ph = 0; ph < 10; ph++) begin
      set_limits(ph[2:0], (ph < 8) ? 2 : ph - 8);
      no_gaps = (ph % 3 == 2);
      for (int k = 0; k < 70; k++) send_trajectory();
      drain();
    end

    drain();
    if (fail_count == 0)
      $display("value_rate_accel_limiter test passed");
    else
      $display("value_rate_accel_limiter test failed");
    $finish;
  end

endmodule

// File: files.f
hdl/vral_pkg.sv
hdl/vral_bounds.sv
hdl/vral_clamp.sv
hdl/vral_div.sv
hdl/value_rate_accel_limiter.sv
test/vral_checker.sv
test/testbench.sv
